FILE: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and the result word type of the text console writer.
// No dependencies.

package tcw_pkg;

	// Field widths fixed by the port list
	localparam int KIND_W   = 3;
	localparam int BYTE_W   = 8;
	localparam int COLUMN_W = 7;
	localparam int LINE_W   = 5;
	localparam int CELL_W   = 16;

	// Default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Operation codes carried in kind
	localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BACK  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

	localparam logic [BYTE_W-1:0] NEWLINE_CODE     = 8'd10;
	localparam logic [BYTE_W-1:0] SPACE_CODE       = 8'd32;
	localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RST = 8'd15;

	typedef struct packed {
		logic [COLUMN_W-1:0] cursor_column;
		logic [LINE_W-1:0]   cursor_row;
		logic                scrolled;
		logic [BYTE_W-1:0]   cell_char;
		logic [BYTE_W-1:0]   cell_attr;
	} res_t;

endpackage

FILE: hw/rtl/tcw_cell_mem.sv
`timescale 1ns / 1ps
// Character-cell store: simple dual-port synchronous RAM, one write and one read port.
// Read data registered. Uses tcw_pkg.

module tcw_cell_mem #(
	parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic                      re,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the text console writer: cursor, scroll ring base, sweeps and memory access.
// Drives tcw_cell_mem; uses tcw_pkg.

module tcw_ctrl #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF,
	parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tcw_pkg::BYTE_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tcw_pkg::KIND_W-1:0]   kind,
	input  logic [tcw_pkg::BYTE_W-1:0]   char_code,
	input  logic [tcw_pkg::BYTE_W-1:0]   attribute,
	input  logic [tcw_pkg::COLUMN_W-1:0] column,
	input  logic [tcw_pkg::LINE_W-1:0]   line,
	output logic                         mem_we,
	output logic [ADDR_W-1:0]            mem_waddr,
	output logic [tcw_pkg::CELL_W-1:0]   mem_wdata,
	output logic                         mem_re,
	output logic [ADDR_W-1:0]            mem_raddr,
	input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata,
	output logic                         res_valid,
	output tcw_pkg::res_t                res,
	input  logic                         out_free
);
	import tcw_pkg::*;

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int CELLS = COLUMNS * ROWS;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_EXEC, ST_RDATA, ST_SWEEP, ST_OUT
	} state_t;

	state_t             state_q;
	logic [KIND_W-1:0]  it_kind_q;
	logic [BYTE_W-1:0]  it_char_q;
	logic [BYTE_W-1:0]  it_attr_q;
	logic [COL_W-1:0]   it_col_q;
	logic [ROW_W-1:0]   it_row_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   base_q;
	logic [ADDR_W-1:0]  base_addr_q;
	logic [BYTE_W-1:0]  defattr_q;
	logic [ADDR_W-1:0]  sw_addr_q;
	logic [ADDR_W-1:0]  sw_last_q;
	logic [CELL_W-1:0]  sw_data_q;
	logic               scr_q;
	logic [CELL_W-1:0]  rd_q;

	logic               accept;
	logic               at_origin;
	logic               is_newline;
	logic               line_end;
	logic [COL_W-1:0]   prev_col;
	logic [ROW_W-1:0]   prev_row;
	logic [COL_W-1:0]   sel_col;
	logic [ROW_W-1:0]   sel_row;
	logic [ROW_W:0]     row_sum;
	logic [ROW_W:0]     phys_row;
	logic [ADDR_W-1:0]  exec_addr;
	logic               exec_we;

	assign in_stall = !(state_q == ST_IDLE || (state_q == ST_OUT && out_free));
	assign accept   = in_valid && !in_stall;

	assign at_origin  = (row_q == '0) && (col_q == '0);
	assign is_newline = (it_char_q == NEWLINE_CODE);
	assign line_end   = is_newline || (32'(col_q) == COLUMNS - 1);

	// Cell before the cursor, wrapping to the last column of the row above
	always_comb begin
		if (col_q != '0) begin
			prev_col = col_q - COL_W'(1);
			prev_row = row_q;
		end else begin
			prev_col = COL_W'(COLUMNS - 1);
			prev_row = row_q - ROW_W'(1);
		end
	end

	always_comb begin
		case (it_kind_q)
			KIND_READ: begin
				sel_col = it_col_q;
				sel_row = it_row_q;
			end
			KIND_BACK: begin
				sel_col = prev_col;
				sel_row = prev_row;
			end
			default: begin
				sel_col = col_q;
				sel_row = row_q;
			end
		endcase
	end

	// Logical row to physical row through the scroll ring base
	assign row_sum  = {1'b0, base_q} + {1'b0, sel_row};
	assign phys_row = (32'(row_sum) >= ROWS) ? row_sum - (ROW_W+1)'(ROWS) : row_sum;
	assign exec_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(sel_col);

	assign exec_we = (state_q == ST_EXEC) &&
		((it_kind_q == KIND_PUT && !is_newline) || (it_kind_q == KIND_BACK && !at_origin));

	always_comb begin
		mem_we    = exec_we || state_q == ST_SWEEP || state_q == ST_INIT;
		mem_waddr = (state_q == ST_SWEEP || state_q == ST_INIT) ? sw_addr_q : exec_addr;
		if (state_q == ST_INIT) begin
			mem_wdata = '0;
		end else if (state_q == ST_SWEEP) begin
			mem_wdata = sw_data_q;
		end else if (it_kind_q == KIND_PUT) begin
			mem_wdata = {it_attr_q, it_char_q};
		end else begin
			mem_wdata = {defattr_q, SPACE_CODE};
		end
		mem_re    = (state_q == ST_EXEC) && (it_kind_q == KIND_READ);
		mem_raddr = exec_addr;
	end

	assign res_valid         = (state_q == ST_OUT);
	assign res.cursor_column = COLUMN_W'(col_q);
	assign res.cursor_row    = LINE_W'(row_q);
	assign res.scrolled      = scr_q;
	assign res.cell_char     = rd_q[BYTE_W-1:0];
	assign res.cell_attr     = rd_q[CELL_W-1:BYTE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			base_addr_q <= '0;
			defattr_q   <= DEFAULT_ATTR_RST;
			sw_addr_q   <= '0;
			sw_last_q   <= ADDR_W'(CELLS - 1);
			sw_data_q   <= '0;
			scr_q       <= 1'b0;
			rd_q        <= '0;
		end else begin
			if (cfg_we) begin
				defattr_q <= cfg_wdata;
			end
			if (accept) begin
				it_kind_q <= kind;
				it_char_q <= char_code;
				it_attr_q <= attribute;
				it_col_q  <= (32'(column) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(column);
				it_row_q  <= (32'(line) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(line);
			end
			case (state_q)
				ST_INIT: begin
					if (sw_addr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						sw_addr_q <= sw_addr_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					scr_q   <= 1'b0;
					rd_q    <= '0;
					state_q <= ST_OUT;
					case (it_kind_q)
						KIND_PUT: begin
							if (line_end) begin
								col_q <= '0;
								if (32'(row_q) == ROWS - 1) begin
									// Retire the top row: it becomes the new bottom row, zeroed
									scr_q     <= 1'b1;
									sw_addr_q <= base_addr_q;
									sw_last_q <= base_addr_q + ADDR_W'(COLUMNS - 1);
									sw_data_q <= '0;
									if (32'(base_q) == ROWS - 1) begin
										base_q      <= '0;
										base_addr_q <= '0;
									end else begin
										base_q      <= base_q + ROW_W'(1);
										base_addr_q <= base_addr_q + ADDR_W'(COLUMNS);
									end
									state_q <= ST_SWEEP;
								end else begin
									row_q <= row_q + ROW_W'(1);
								end
							end else begin
								col_q <= col_q + COL_W'(1);
							end
						end
						KIND_SET: begin
							col_q <= it_col_q;
							row_q <= it_row_q;
						end
						KIND_BACK: begin
							if (!at_origin) begin
								col_q <= prev_col;
								row_q <= prev_row;
							end
						end
						KIND_CLEAR: begin
							col_q       <= '0;
							row_q       <= '0;
							base_q      <= '0;
							base_addr_q <= '0;
							sw_addr_q   <= '0;
							sw_last_q   <= ADDR_W'(CELLS - 1);
							sw_data_q   <= {defattr_q, SPACE_CODE};
							state_q     <= ST_SWEEP;
						end
						KIND_READ: begin
							state_q <= ST_RDATA;
						end
						default: begin
						end
					endcase
				end
				ST_RDATA: begin
					rd_q    <= mem_rdata;
					state_q <= ST_OUT;
				end
				ST_SWEEP: begin
					if (sw_addr_q == sw_last_q) begin
						state_q <= ST_OUT;
					end else begin
						sw_addr_q <= sw_addr_q + ADDR_W'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= accept ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Cursor and ring base stay on screen
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < ROWS) && (32'(col_q) < COLUMNS) && (32'(base_q) < ROWS))
		else $error("cursor or ring base off screen");

	// Ring base address tracks the base row
	a_base_addr: assert property (@(posedge clk) disable iff (!arst_n)
		32'(base_addr_q) == 32'(base_q) * COLUMNS)
		else $error("ring base address out of step");

	// An accepted word is executed in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted word not executed");

	// A sweep never runs past its last entry
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> sw_addr_q <= sw_last_q)
		else $error("sweep overran");

	// No store access while idle or presenting a result
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_OUT) |-> !mem_we && !mem_re)
		else $error("store access outside execution");

endmodule

FILE: hw/rtl/text_console_writer.sv
`timescale 1ns / 1ps
// Top level of the text console writer: sequencer, cell store and output register.
// Uses tcw_pkg, tcw_ctrl and tcw_cell_mem.

// Text console: a screen of ROWS by COLUMNS cells (character in the low byte, attribute in
// the high byte) held in one synchronous RAM, plus a cursor. Each input word gives exactly
// one result word carrying the cursor after the operation, a scroll flag and, for a cell
// read, the addressed cell. Words take one at a time through a sequencer: put char, newline,
// set cursor and backspace pass from acceptance through the execute state to the result; a
// cell read adds a state that takes the registered RAM read data. Scrolling keeps the rows
// as a ring in the RAM, so a scroll only blanks the retired top row to zero. Clear screen
// writes a space with default_attribute into every cell. After reset the RAM is zeroed with
// in_stall high; writes to default_attribute (cfg_we / cfg_wdata) are taken at any time but
// must only be made while the block is idle. The output register lets the next word be
// accepted while a result waits on out_stall. Positions given for set cursor and read cell
// saturate to the last column and row.

module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tcw_pkg::BYTE_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tcw_pkg::KIND_W-1:0]   kind,
	input  logic [tcw_pkg::BYTE_W-1:0]   char_code,
	input  logic [tcw_pkg::BYTE_W-1:0]   attribute,
	input  logic [tcw_pkg::COLUMN_W-1:0] column,
	input  logic [tcw_pkg::LINE_W-1:0]   line,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tcw_pkg::COLUMN_W-1:0] cursor_column,
	output logic [tcw_pkg::LINE_W-1:0]   cursor_row,
	output logic                         scrolled,
	output logic [tcw_pkg::BYTE_W-1:0]   cell_char,
	output logic [tcw_pkg::BYTE_W-1:0]   cell_attr
);
	import tcw_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;
	logic              res_valid;
	res_t              res;
	logic              out_free;
	logic              out_valid_q;
	res_t              out_q;

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.ADDR_W  (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.char_code (char_code),
		.attribute (attribute),
		.column    (column),
		.line      (line),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free)
	);

	tcw_cell_mem #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_cell_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			// Load the pending result, or drop the word just taken
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_column = out_q.cursor_column;
	assign cursor_row    = out_q.cursor_row;
	assign scrolled      = out_q.scrolled;
	assign cell_char     = out_q.cell_char;
	assign cell_attr     = out_q.cell_attr;

endmodule
